@@ rtl/wtsp_pkg.sv @@
// ---------------------------------------------------------------------------
// World to screen projection package
// Shared constants, register codes and transfer payload types.
// ---------------------------------------------------------------------------
`default_nettype none

package wtsp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SIZE_BITS = 14;
	localparam int COORD_W   = 32;
	localparam int CLIP_W    = 50;
	localparam int REM_W     = CLIP_W + 1;
	localparam int QB        = 18;
	localparam int DIV_PER   = 2;
	localparam int DIV_ST    = QB / DIV_PER;
	localparam int QS_W      = QB + 2;
	localparam int QC_W      = QB + 1;
	localparam int PROD_W    = SIZE_BITS + 1 + QC_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int ADDR_W    = 6;
	localparam int DATA_W    = 64;
	localparam int W_MIN     = ((1 << FRAC_BITS) + 999) / 1000;

	localparam logic signed [QS_W-1:0] Q_MAX = QS_W'(1 << (QB - 1));
	localparam logic signed [QS_W-1:0] Q_MIN = -QS_W'(1 << (QB - 1)) - QS_W'(1);
	localparam logic [SIZE_BITS-1:0] WIDTH_RST  = SIZE_BITS'(1920);
	localparam logic [SIZE_BITS-1:0] HEIGHT_RST = SIZE_BITS'(1080);

	typedef enum logic [2:0] {
		REG_ROW0_01 = 3'd0,
		REG_ROW0_23 = 3'd1,
		REG_ROW1_01 = 3'd2,
		REG_ROW1_23 = 3'd3,
		REG_ROW3_01 = 3'd4,
		REG_ROW3_23 = 3'd5,
		REG_WIDTH   = 3'd6,
		REG_HEIGHT  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic               in_front;
	} screen_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QB-1:0]    mlo;
		logic [QB-1:0]    q;
		logic             neg;
		logic             ovf;
	} div_t;

	typedef struct packed {
		logic signed [QC_W-1:0] qp1;
		logic [REM_W-1:0]       rem;
		logic [SIZE_BITS-1:0]   fq;
		logic [CLIP_W-1:0]      r;
	} mf_t;

endpackage

`default_nettype wire

@@ rtl/world_to_screen_projection.sv @@
// Throughput: one point per cycle; the whole pipeline holds while the
// result register is full and stalled.
// Reset: all valid bits clear, the matrix registers reset to zero and the
// viewport to 1920 by 1080.
// ---------------------------------------------------------------------------
// World to screen projection
// Matrix products, clip sums and pixel mapping with an APB register port.
// ---------------------------------------------------------------------------
`default_nettype none

module world_to_screen_projection (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire logic [wtsp_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [wtsp_pkg::DATA_W-1:0]    pwdata,
	output logic [wtsp_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  wire                                 point_valid,
	output logic                                point_stall,
	input  wire wtsp_pkg::point_t               point,
	output logic                                screen_valid,
	input  wire                                 screen_stall,
	output wtsp_pkg::screen_t                   screen
);
	import wtsp_pkg::*;

	logic [DATA_W-1:0]    mat_q [6];
	logic [SIZE_BITS-1:0] width_q;
	logic [SIZE_BITS-1:0] height_q;
	reg_idx_t             idx;
	logic                 en;

	logic                      v_s1;
	logic signed [63:0]        prod_s1 [3][3];
	logic signed [COORD_W-1:0] c3_s1 [3];
	logic                      v_s2;
	logic signed [CLIP_W-1:0]  clip_s2 [3];
	logic signed [CLIP_W-1:0]  clip_d [3];
	logic signed [COORD_W-1:0] coord [3];

	assign idx = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign pready = 1'b1;
	assign en = !(screen_valid && screen_stall);
	assign point_stall = !en;
	assign coord[0] = point.point_x;
	assign coord[1] = point.point_y;
	assign coord[2] = point.point_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				mat_q[i] <= '0;
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_ROW0_01: mat_q[0] <= pwdata;
				REG_ROW0_23: mat_q[1] <= pwdata;
				REG_ROW1_01: mat_q[2] <= pwdata;
				REG_ROW1_23: mat_q[3] <= pwdata;
				REG_ROW3_01: mat_q[4] <= pwdata;
				REG_ROW3_23: mat_q[5] <= pwdata;
				REG_WIDTH:   width_q <= pwdata[SIZE_BITS-1:0];
				REG_HEIGHT:  height_q <= pwdata[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ROW0_01: prdata = mat_q[0];
			REG_ROW0_23: prdata = mat_q[1];
			REG_ROW1_01: prdata = mat_q[2];
			REG_ROW1_23: prdata = mat_q[3];
			REG_ROW3_01: prdata = mat_q[4];
			REG_ROW3_23: prdata = mat_q[5];
			REG_WIDTH:   prdata = DATA_W'(width_q);
			REG_HEIGHT:  prdata = DATA_W'(height_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= point_valid;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		logic signed [63:0] sh;
		for (int r = 0; r < 3; r++) begin
			clip_d[r] = CLIP_W'(c3_s1[r]);
			for (int c = 0; c < 3; c++) begin
				sh = prod_s1[r][c] >>> FRAC_BITS;
				clip_d[r] = clip_d[r] + sh[CLIP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++)
					prod_s1[r][c] <= $signed(mat_q[2*r + c/2][32*(c%2) +: 32]) * coord[c];
				c3_s1[r] <= $signed(mat_q[2*r + 1][63:32]);
				clip_s2[r] <= clip_d[r];
			end
		end
	end

	wtsp_proj u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.cx        (clip_s2[0]),
		.cy        (clip_s2[1]),
		.cw        (clip_s2[2]),
		.width     (width_q),
		.height    (height_q),
		.out_valid (screen_valid),
		.out_data  (screen)
	);

endmodule

`default_nettype wire

@@ rtl/wtsp_proj.sv @@
// ---------------------------------------------------------------------------
// Pixel mapping pipeline
// Divides clip x and -y by w, maps the quotients to pixels and saturates.
// ---------------------------------------------------------------------------
`default_nettype none

module wtsp_proj (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 en,
	input  wire                                 in_valid,
	input  wire logic signed [wtsp_pkg::CLIP_W-1:0] cx,
	input  wire logic signed [wtsp_pkg::CLIP_W-1:0] cy,
	input  wire logic signed [wtsp_pkg::CLIP_W-1:0] cw,
	input  wire logic [wtsp_pkg::SIZE_BITS-1:0]     width,
	input  wire logic [wtsp_pkg::SIZE_BITS-1:0]     height,
	output logic                                out_valid,
	output wtsp_pkg::screen_t                   out_data
);
	import wtsp_pkg::*;

	localparam int FIN = DIV_ST + 1;
	localparam int MUL = FIN + SIZE_BITS + 1;
	localparam int NST = MUL + 1;
	localparam int NW  = FIN + SIZE_BITS;

	logic                 vld_s [NST];
	logic                 frt_s [NST];
	logic [CLIP_W-1:0]    wa_s  [NW];
	div_t                 dv_s  [DIV_ST+1][2];
	mf_t                  mf_s  [SIZE_BITS+1][2];
	logic signed [PROD_W-1:0]  prod_sm [2];
	logic [SIZE_BITS-1:0] fq_sm [2];

	div_t                 dv_d  [DIV_ST+1][2];
	mf_t                  mf_d  [SIZE_BITS+1][2];
	logic signed [PROD_W-1:0]  prod_d [2];
	screen_t              out_d;
	logic                 front_d;
	logic [SIZE_BITS-1:0] size_l [2];

	assign size_l[0] = width;
	assign size_l[1] = height;

	function automatic div_t div_step(input div_t d, input logic [CLIP_W-1:0] w);
		logic [REM_W-1:0] r2;
		div_t o;
		o = d;
		r2 = {d.rem[REM_W-2:0], d.mlo[QB-1]};
		o.mlo = {d.mlo[QB-2:0], 1'b0};
		if (r2 >= {1'b0, w}) begin
			o.rem = r2 - {1'b0, w};
			o.q = {d.q[QB-2:0], 1'b1};
		end else begin
			o.rem = r2;
			o.q = {d.q[QB-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic mf_t mf_step(input mf_t d, input logic [CLIP_W-1:0] w,
		input logic sbit);
		logic [REM_W-1:0] r1;
		logic [SIZE_BITS-1:0] f1;
		mf_t o;
		o = d;
		r1 = {d.rem[REM_W-2:0], 1'b0};
		f1 = {d.fq[SIZE_BITS-2:0], 1'b0};
		if (r1 >= {1'b0, w}) begin
			r1 = r1 - {1'b0, w};
			f1 = f1 + SIZE_BITS'(1);
		end
		if (sbit) begin
			r1 = r1 + {1'b0, d.r};
			if (r1 >= {1'b0, w}) begin
				r1 = r1 - {1'b0, w};
				f1 = f1 + SIZE_BITS'(1);
			end
		end
		o.rem = r1;
		o.fq = f1;
		return o;
	endfunction

	always_comb begin
		logic signed [CLIP_W-1:0] n [2];
		logic [CLIP_W-1:0] m;
		logic [CLIP_W-1:0] hi;
		logic signed [QS_W-1:0] qs;
		logic signed [QS_W-1:0] qc;
		logic [CLIP_W-1:0] rr;
		logic signed [SUM_W-1:0] c;
		logic signed [SUM_W-1:0] h;
		logic signed [15:0] sat [2];
		n[0] = cx;
		n[1] = -cy;
		front_d = (cw >= CLIP_W'(W_MIN));
		for (int l = 0; l < 2; l++) begin
			m = n[l][CLIP_W-1] ? ~n[l] : n[l];
			hi = m >> QB;
			dv_d[0][l].rem = {1'b0, hi};
			dv_d[0][l].mlo = m[QB-1:0];
			dv_d[0][l].q = '0;
			dv_d[0][l].neg = n[l][CLIP_W-1];
			dv_d[0][l].ovf = (hi >= cw);
		end
		for (int k = 1; k <= DIV_ST; k++) begin
			for (int l = 0; l < 2; l++) begin
				dv_d[k][l] = dv_s[k-1][l];
				for (int j = 0; j < DIV_PER; j++)
					dv_d[k][l] = div_step(dv_d[k][l], wa_s[k-1]);
			end
		end
		for (int l = 0; l < 2; l++) begin
			qs = QS_W'(dv_s[DIV_ST][l].q);
			rr = dv_s[DIV_ST][l].rem[CLIP_W-1:0];
			if (dv_s[DIV_ST][l].neg) begin
				qs = -qs - QS_W'(1);
				rr = wa_s[DIV_ST] - CLIP_W'(1) - rr;
			end
			qc = qs;
			if (dv_s[DIV_ST][l].ovf) begin
				qc = dv_s[DIV_ST][l].neg ? Q_MIN : Q_MAX;
				rr = '0;
			end else if (qs > Q_MAX) begin
				qc = Q_MAX;
				rr = '0;
			end else if (qs < Q_MIN) begin
				qc = Q_MIN;
				rr = '0;
			end
			mf_d[0][l].qp1 = QC_W'(qc + QS_W'(1));
			mf_d[0][l].rem = '0;
			mf_d[0][l].fq = '0;
			mf_d[0][l].r = rr;
		end
		for (int k = 1; k <= SIZE_BITS; k++) begin
			for (int l = 0; l < 2; l++)
				mf_d[k][l] = mf_step(mf_s[k-1][l], wa_s[FIN+k-1],
					size_l[l][SIZE_BITS-k]);
		end
		for (int l = 0; l < 2; l++)
			prod_d[l] = $signed({1'b0, size_l[l]}) * mf_s[SIZE_BITS][l].qp1;
		for (int l = 0; l < 2; l++) begin
			c = SUM_W'(prod_sm[l]) + $signed({1'b0, fq_sm[l]});
			c = (l == 0) ? c + SUM_W'(1) : c - SUM_W'(1);
			h = c >>> 1;
			if (h > SUM_W'(32767))
				sat[l] = 16'sd32767;
			else if (h < -SUM_W'(32768))
				sat[l] = -16'sd32768;
			else
				sat[l] = h[15:0];
		end
		out_d.in_front = frt_s[MUL];
		out_d.screen_x = frt_s[MUL] ? sat[0] : '0;
		out_d.screen_y = frt_s[MUL] ? sat[1] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++)
				vld_s[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < NST; k++)
				vld_s[k] <= vld_s[k-1];
			out_valid <= vld_s[MUL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frt_s[0] <= front_d;
			for (int k = 1; k < NST; k++)
				frt_s[k] <= frt_s[k-1];
			wa_s[0] <= cw;
			for (int k = 1; k < NW; k++)
				wa_s[k] <= wa_s[k-1];
			for (int k = 0; k <= DIV_ST; k++)
				for (int l = 0; l < 2; l++)
					dv_s[k][l] <= dv_d[k][l];
			for (int k = 0; k <= SIZE_BITS; k++)
				for (int l = 0; l < 2; l++)
					mf_s[k][l] <= mf_d[k][l];
			for (int l = 0; l < 2; l++) begin
				prod_sm[l] <= prod_d[l];
				fq_sm[l] <= mf_s[SIZE_BITS][l].fq;
			end
			out_data <= out_d;
		end
	end

endmodule

`default_nettype wire
